[rtl/i2cmq_pkg.sv]
package i2cmq_pkg;

  // ring geometry
  localparam int QUEUE_DEPTH    = 32;
  localparam int MSG_BYTES      = 128;
  localparam int SLOT_W         = $clog2(QUEUE_DEPTH);
  localparam int LANES          = 8;
  localparam int LANE_W         = $clog2(LANES);
  localparam int WORDS_PER_SLOT = MSG_BYTES / LANES;
  localparam int WORD_W         = $clog2(WORDS_PER_SLOT);
  localparam int RAM_AW         = SLOT_W + WORD_W;
  localparam int RAM_DEPTH      = QUEUE_DEPTH * WORDS_PER_SLOT;

  // field widths
  localparam int KIND_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 8;
  localparam int ADDR_W  = 7;
  localparam int CHUNK_W = BYTE_W * LANES;
  localparam int NB_W    = 4;

  localparam logic [LEN_W-1:0]  MIN_COMMIT_LEN = LEN_W'(2);
  localparam logic [BYTE_W-1:0] OTHER_BUS_BYTE = 8'hFF;

  // bus and host event codes
  typedef enum logic [KIND_W-1:0] {
    KIND_WSTART = 3'd0,
    KIND_BYTE   = 3'd1,
    KIND_STOP   = 3'd2,
    KIND_POP    = 3'd3,
    KIND_OTHER  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    POP_NONE      = 2'd0,
    POP_DELIVERED = 2'd1,
    POP_EMPTY     = 2'd2,
    POP_TOO_LONG  = 2'd3
  } pop_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_STREAM
  } state_t;

  // byte-lane write into the message ram
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [LANE_W-1:0] lane;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    n = s + 1'b1;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) n = '0;
    return n;
  endfunction

endpackage

[rtl/i2cmq_msg_ram.sv]
module i2cmq_msg_ram (
  input  logic                            clk,
  input  i2cmq_pkg::ram_wr_t              wr,
  input  logic [i2cmq_pkg::RAM_AW-1:0]    rd_addr,
  output logic [i2cmq_pkg::CHUNK_W-1:0]   rd_data
);
  import i2cmq_pkg::*;

  logic [CHUNK_W-1:0] mem_r [RAM_DEPTH];
  logic [CHUNK_W-1:0] rd_data_r;

  // one byte lane written, one full word read, registered
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr][wr.lane*BYTE_W +: BYTE_W] <= wr.data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/i2c_slave_message_queue_unit.sv]
// I2C slave receive message queue.
// Input channel: an event (in_kind, in_data_byte, in_read_limit) is taken at
// a clock edge with start high and busy low. Configuration: cfg_wr_en writes
// the 7-bit own address from cfg_wr_data; the user must write it only while
// idle, the block does not enforce this. Result channel: every word sits on
// the out_ ports for one cycle, flagged by out_strobe. The receiver cannot
// stall, so results are never held back. Bus events (write start, byte, stop,
// other) give one result in the cycle after acceptance and leave busy low:
// one event per cycle is sustained while no pop holds busy high. A pop on an
// empty ring answers the same way. A pop of a stored message first fetches
// the slot length (ST_DECIDE), then streams its 8-byte chunks one per cycle
// from the single 64-bit read port of the message ram (ST_STREAM), busy high
// throughout: 16 chunks for a full 128-byte message, none if too long/empty.
// Reset clears the slot pointers, the truncation flag and the current length.
// The length table is written on every commit before it can be read, and the
// message ram holds no reset: no clearing pass is needed.
module i2c_slave_message_queue_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [i2cmq_pkg::KIND_W-1:0]    in_kind,
  input  logic [i2cmq_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic [i2cmq_pkg::LEN_W-1:0]     in_read_limit,
  input  logic                            cfg_wr_en,
  input  logic [i2cmq_pkg::ADDR_W-1:0]    cfg_wr_data,
  output logic                            out_strobe,
  output logic [i2cmq_pkg::BYTE_W-1:0]    out_bus_byte,
  output logic                            out_truncated_error,
  output logic [1:0]                      out_pop_status,
  output logic [i2cmq_pkg::LEN_W-1:0]     out_message_length,
  output logic [i2cmq_pkg::CHUNK_W-1:0]   out_chunk_data,
  output logic [i2cmq_pkg::NB_W-1:0]      out_chunk_bytes,
  output logic                            out_last_chunk,
  output logic                            out_more_pending,
  output logic                            out_message_committed
);
  import i2cmq_pkg::*;

  // control state
  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   ws_r, ws_nxt;
  logic [SLOT_W-1:0]   rs_r, rs_nxt;
  logic                trunc_r, trunc_nxt;
  logic [LEN_W-1:0]    cur_len_r, cur_len_nxt;
  logic [ADDR_W-1:0]   own_addr_r;
  logic                out_strobe_r, out_strobe_nxt;

  // pop working registers
  logic [SLOT_W-1:0]   rd_slot_r, rd_slot_nxt;
  logic [WORD_W-1:0]   widx_r, widx_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [LEN_W-1:0]    limit_r, limit_nxt;
  logic [LEN_W-1:0]    msg_len_r, msg_len_nxt;
  logic                more_r, more_nxt;

  // length table
  logic [LEN_W-1:0]    len_mem_r [QUEUE_DEPTH];
  logic [LEN_W-1:0]    len_q_r;
  logic                len_we;

  // output payload
  logic [BYTE_W-1:0]   bus_byte_r, bus_byte_nxt;
  logic                terr_r, terr_nxt;
  pop_status_t         pst_r, pst_nxt;
  logic [LEN_W-1:0]    olen_r, olen_nxt;
  logic [CHUNK_W-1:0]  data_r, data_nxt;
  logic [NB_W-1:0]     nb_r, nb_nxt;
  logic                last_r, last_nxt;
  logic                omore_r, omore_nxt;
  logic                commit_r, commit_nxt;

  ram_wr_t             ram_wr;
  logic [RAM_AW-1:0]   ram_rd_addr;
  logic [CHUNK_W-1:0]  ram_rd_data;

  logic                accept;
  logic [SLOT_W-1:0]   ws_inc;
  logic [SLOT_W-1:0]   rs_inc;

  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r != ST_IDLE);
  assign ws_inc      = next_slot(ws_r);
  assign rs_inc      = next_slot(rs_r);
  assign ram_rd_addr = {rd_slot_r, widx_r};

  i2cmq_msg_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // state and pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ws_r         <= '0;
      rs_r         <= '0;
      trunc_r      <= 1'b0;
      cur_len_r    <= '0;
      own_addr_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ws_r         <= ws_nxt;
      rs_r         <= rs_nxt;
      trunc_r      <= trunc_nxt;
      cur_len_r    <= cur_len_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        own_addr_r <= cfg_wr_data;
      end
    end
  end

  // payload registers and length table
  always_ff @(posedge clk) begin
    rd_slot_r  <= rd_slot_nxt;
    widx_r     <= widx_nxt;
    rem_r      <= rem_nxt;
    limit_r    <= limit_nxt;
    msg_len_r  <= msg_len_nxt;
    more_r     <= more_nxt;
    bus_byte_r <= bus_byte_nxt;
    terr_r     <= terr_nxt;
    pst_r      <= pst_nxt;
    olen_r     <= olen_nxt;
    data_r     <= data_nxt;
    nb_r       <= nb_nxt;
    last_r     <= last_nxt;
    omore_r    <= omore_nxt;
    commit_r   <= commit_nxt;
    if (len_we) begin
      len_mem_r[ws_r] <= cur_len_r;
    end
    len_q_r <= len_mem_r[rs_r];
  end

  // sequencer: next state, pointers and result word
  always_comb begin
    state_nxt      = state_r;
    ws_nxt         = ws_r;
    rs_nxt         = rs_r;
    trunc_nxt      = trunc_r;
    cur_len_nxt    = cur_len_r;
    rd_slot_nxt    = rd_slot_r;
    widx_nxt       = widx_r;
    rem_nxt        = rem_r;
    limit_nxt      = limit_r;
    msg_len_nxt    = msg_len_r;
    more_nxt       = more_r;
    len_we         = 1'b0;
    ram_wr         = '0;
    out_strobe_nxt = 1'b0;
    bus_byte_nxt   = '0;
    terr_nxt       = 1'b0;
    pst_nxt        = POP_NONE;
    olen_nxt       = '0;
    data_nxt       = '0;
    nb_nxt         = '0;
    last_nxt       = 1'b1;
    omore_nxt      = 1'b0;
    commit_nxt     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_strobe_nxt = 1'b1;
          case (in_kind)
            KIND_WSTART: begin
              trunc_nxt   = 1'b0;
              cur_len_nxt = LEN_W'(1);
              ram_wr.en   = 1'b1;
              ram_wr.addr = {ws_r, WORD_W'(0)};
              ram_wr.lane = '0;
              ram_wr.data = {own_addr_r, 1'b0};
            end
            KIND_BYTE: begin
              if (cur_len_r < LEN_W'(MSG_BYTES)) begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = {ws_r, cur_len_r[LANE_W +: WORD_W]};
                ram_wr.lane = cur_len_r[LANE_W-1:0];
                ram_wr.data = in_data_byte;
                cur_len_nxt = cur_len_r + 1'b1;
              end else begin
                trunc_nxt = 1'b1;
                terr_nxt  = 1'b1;
              end
            end
            KIND_STOP: begin
              if (!trunc_r && (cur_len_r >= MIN_COMMIT_LEN)) begin
                len_we      = 1'b1;
                ws_nxt      = ws_inc;
                cur_len_nxt = '0;
                commit_nxt  = 1'b1;
                // ring full: drop the oldest message
                if (rs_r == ws_inc) begin
                  rs_nxt = rs_inc;
                end
              end
            end
            KIND_POP: begin
              if (rs_r == ws_r) begin
                pst_nxt = POP_EMPTY;
              end else begin
                // length is fetched at this edge, decided next cycle
                out_strobe_nxt = 1'b0;
                limit_nxt      = in_read_limit;
                rd_slot_nxt    = rs_r;
                widx_nxt       = '0;
                state_nxt      = ST_DECIDE;
              end
            end
            default: begin
              bus_byte_nxt = OTHER_BUS_BYTE;
            end
          endcase
        end
      end

      ST_DECIDE: begin
        rs_nxt      = rs_inc;
        more_nxt    = (rs_inc != ws_r);
        msg_len_nxt = len_q_r;
        rem_nxt     = len_q_r;
        if (len_q_r > limit_r) begin
          out_strobe_nxt = 1'b1;
          pst_nxt        = POP_TOO_LONG;
          olen_nxt       = len_q_r;
          omore_nxt      = (rs_inc != ws_r);
          state_nxt      = ST_IDLE;
        end else if (len_q_r == '0) begin
          out_strobe_nxt = 1'b1;
          pst_nxt        = POP_DELIVERED;
          omore_nxt      = (rs_inc != ws_r);
          state_nxt      = ST_IDLE;
        end else begin
          // word 0 is read at this edge
          widx_nxt  = widx_r + 1'b1;
          state_nxt = ST_STREAM;
        end
      end

      ST_STREAM: begin
        out_strobe_nxt = 1'b1;
        pst_nxt        = POP_DELIVERED;
        olen_nxt       = msg_len_r;
        omore_nxt      = more_r;
        // keep only the bytes that belong to the message
        for (int b = 0; b < LANES; b++) begin
          if (LEN_W'(b) < rem_r) begin
            data_nxt[b*BYTE_W +: BYTE_W] = ram_rd_data[b*BYTE_W +: BYTE_W];
          end
        end
        if (rem_r > LEN_W'(LANES)) begin
          nb_nxt    = NB_W'(LANES);
          last_nxt  = 1'b0;
          rem_nxt   = rem_r - LEN_W'(LANES);
          widx_nxt  = widx_r + 1'b1;
        end else begin
          nb_nxt    = rem_r[NB_W-1:0];
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_strobe            = out_strobe_r;
  assign out_bus_byte          = bus_byte_r;
  assign out_truncated_error   = terr_r;
  assign out_pop_status        = pst_r;
  assign out_message_length    = olen_r;
  assign out_chunk_data        = data_r;
  assign out_chunk_bytes       = nb_r;
  assign out_last_chunk        = last_r;
  assign out_more_pending      = omore_r;
  assign out_message_committed = commit_r;

  // a chunk that is not the last is always followed by more streaming
  a_chunk_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !last_r) |-> (state_r == ST_STREAM))
    else $error("non-final chunk without streaming");

  // streaming produces a result word every cycle
  a_stream_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STREAM) |=> out_strobe_r)
    else $error("missing chunk during streaming");

  // a commit advances the write slot by exactly one
  a_commit_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && commit_r) |-> (ws_r == next_slot($past(ws_r))))
    else $error("commit without write slot advance");

  // the current slot length never exceeds the slot size
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_len_r <= LEN_W'(MSG_BYTES))
    else $error("slot length beyond slot size");

endmodule
